[sv/eac_pkg.sv]
// shared constants, types and arithmetic helpers for the euler angle composition block
package eac_pkg;

  localparam int ANGLE_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // input angles carry 13 fraction bits, internal angles 30
  localparam int FRAC_SHIFT = 17;

  localparam int SC_W    = 34;  // sin/cos cordic datapath
  localparam int SIN_W   = 32;  // sine and cosine, q30
  localparam int MAT_W   = 33;  // rotation matrix entries, q30
  localparam int F_W     = 36;  // composed matrix entries, q30
  localparam int AT_W    = 38;  // vectoring cordic x and y
  localparam int AZ_W    = 36;  // vectoring cordic angle, q30
  localparam int SAT_W   = 32;  // saturated asin argument
  localparam int ROOT_W  = 31;  // integer square root result
  localparam int RAD_W   = 62;  // square root remainder
  localparam int OUT_W   = 16;  // roll and yaw result width
  localparam int PITCH_W = 15;  // pitch result width

  // asin front end: saturate, square, remainder, then one root bit per stage
  localparam int ASIN_STAGES = 3 + ROOT_W;

  localparam logic signed [63:0] Q_PI        = 64'sd3373259426;
  localparam logic signed [63:0] Q_HALF_PI   = 64'sd1686629713;
  localparam logic signed [63:0] Q_TWO_PI    = 64'sd6746518852;
  localparam logic signed [63:0] Q_ONE       = 64'sd1073741824;
  localparam logic signed [63:0] CORDIC_GAIN = 64'sd652032874;

  localparam logic signed [OUT_W-1:0] OUT_PI      = 16'sd25736;
  localparam logic signed [OUT_W-1:0] OUT_HALF_PI = 16'sd12868;

  localparam logic signed [2*MAT_W-1:0] QRND    = (2*MAT_W)'(64'sd536870912);
  localparam logic signed [AZ_W:0]      OUT_RND = (AZ_W+1)'(64'sd65536);

  // selected entries of the composed matrix
  typedef struct packed {
    logic signed [F_W-1:0] f00;
    logic signed [F_W-1:0] f10;
    logic signed [F_W-1:0] f20;
    logic signed [F_W-1:0] f21;
    logic signed [F_W-1:0] f22;
  } fsel_t;

  // atan(2^-k) in q30
  function automatic logic [31:0] atan_at(input int k);
    logic [31:0] v;
    case (k)
      0:  v = 32'd843314856;
      1:  v = 32'd497837829;
      2:  v = 32'd263043836;
      3:  v = 32'd133525158;
      4:  v = 32'd67021686;
      5:  v = 32'd33543515;
      6:  v = 32'd16775850;
      7:  v = 32'd8388437;
      8:  v = 32'd4194282;
      9:  v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      14: v = 32'd65535;
      15: v = 32'd32767;
      16: v = 32'd16383;
      17: v = 32'd8191;
      18: v = 32'd4095;
      19: v = 32'd2047;
      20: v = 32'd1023;
      21: v = 32'd511;
      22: v = 32'd255;
      23: v = 32'd127;
      24: v = 32'd63;
      25: v = 32'd31;
      26: v = 32'd15;
      27: v = 32'd8;
      28: v = 32'd4;
      29: v = 32'd2;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // q30 product, rounded half up
  function automatic logic signed [MAT_W-1:0] qmul(input logic signed [MAT_W-1:0] a,
                                                   input logic signed [MAT_W-1:0] b);
    logic signed [2*MAT_W-1:0] p;
    p = a * b;
    p = p + QRND;
    return p[MAT_W+29:30];
  endfunction

  // q30 angle to 13 fraction bits, rounded half up and clamped
  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [AZ_W:0] z,
                                                     input logic signed [OUT_W-1:0] lim);
    logic signed [AZ_W:0]    zr;
    logic signed [AZ_W-17:0] q;
    logic signed [OUT_W-1:0] r;
    zr = z + OUT_RND;
    q  = zr[AZ_W:17];
    if (q > lim) begin
      r = lim;
    end else if (q < -lim) begin
      r = -lim;
    end else begin
      r = OUT_W'(q);
    end
    return r;
  endfunction

endpackage

[sv/eac_sincos.sv]
// pipelined sine and cosine: range reduction then rotation-mode cordic
module eac_sincos #(
  parameter int ANGLE_WIDTH  = eac_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = eac_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [ANGLE_WIDTH-1:0]    angle,
  output logic signed [eac_pkg::SIN_W-1:0] sin_q,
  output logic signed [eac_pkg::SIN_W-1:0] cos_q
);
  import eac_pkg::*;

  localparam int RS   = (ANGLE_WIDTH > 16) ? ANGLE_WIDTH - 16 : 0;
  localparam int NRED = RS + 1;
  localparam int UW   = 35 + RS;

  localparam logic signed [UW:0] WRAP_OFS = (UW+1)'(Q_TWO_PI <<< RS);
  localparam logic signed [UW:0] HP_U     = (UW+1)'(Q_HALF_PI);
  localparam logic signed [UW:0] PI_U     = (UW+1)'(Q_PI);
  localparam logic signed [UW:0] TP_U     = (UW+1)'(Q_TWO_PI);
  localparam logic signed [UW:0] THP_U    = (UW+1)'(Q_HALF_PI * 3);

  logic signed [UW:0]     ang_ext;
  logic signed [UW:0]     ang_ofs;
  logic        [UW-1:0]   red [NRED+1];
  logic signed [UW:0]     fold_in;
  logic signed [UW:0]     fold_z;
  logic                   fold_flip;
  logic signed [SC_W-1:0] cx [CORDIC_STEPS+1];
  logic signed [SC_W-1:0] cy [CORDIC_STEPS+1];
  logic signed [SC_W-1:0] cz [CORDIC_STEPS+1];
  logic                   cflip [CORDIC_STEPS+1];

  // make the angle non-negative so a plain restoring reduction works
  assign ang_ext = (UW+1)'(angle) <<< FRAC_SHIFT;
  assign ang_ofs = (ang_ext < 0) ? ang_ext + WRAP_OFS : ang_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      red[0] <= ang_ofs[UW-1:0];
    end
  end

  for (genvar s = 0; s < NRED; s++) begin : g_red
    localparam logic [UW-1:0] MOD_K = UW'(Q_TWO_PI <<< (RS - s));
    always_ff @(posedge clk) begin
      if (en) begin
        red[s+1] <= (red[s] >= MOD_K) ? red[s] - MOD_K : red[s];
      end
    end
  end

  // fold [0, 2pi) into [-pi/2, pi/2], flip marks a half turn
  assign fold_in = signed'({1'b0, red[NRED]});

  always_comb begin
    fold_z    = fold_in;
    fold_flip = 1'b0;
    if (fold_in > HP_U && fold_in < THP_U) begin
      fold_z    = fold_in - PI_U;
      fold_flip = 1'b1;
    end else if (fold_in >= THP_U) begin
      fold_z = fold_in - TP_U;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]    <= SC_W'(CORDIC_GAIN);
      cy[0]    <= '0;
      cz[0]    <= SC_W'(fold_z);
      cflip[0] <= fold_flip;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam logic signed [SC_W-1:0] ATN = SC_W'(atan_at(i));
    always_ff @(posedge clk) begin
      if (en) begin
        cflip[i+1] <= cflip[i];
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATN;
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (cflip[CORDIC_STEPS]) begin
        sin_q <= SIN_W'(-cy[CORDIC_STEPS]);
        cos_q <= SIN_W'(-cx[CORDIC_STEPS]);
      end else begin
        sin_q <= SIN_W'(cy[CORDIC_STEPS]);
        cos_q <= SIN_W'(cx[CORDIC_STEPS]);
      end
    end
  end

endmodule

[sv/eac_rotation.sv]
// zyx rotation matrix from sines and cosines, three register stages
module eac_rotation (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [eac_pkg::SIN_W-1:0] sr,
  input  logic signed [eac_pkg::SIN_W-1:0] cr,
  input  logic signed [eac_pkg::SIN_W-1:0] sp,
  input  logic signed [eac_pkg::SIN_W-1:0] cp,
  input  logic signed [eac_pkg::SIN_W-1:0] sy,
  input  logic signed [eac_pkg::SIN_W-1:0] cy,
  output logic signed [eac_pkg::MAT_W-1:0] m [9]
);
  import eac_pkg::*;

  logic signed [MAT_W-1:0] xr_r, xc_r, xp_s, xp_c, xy_s, xy_c;
  logic signed [MAT_W-1:0] s1_m0, s1_m3, s1_m6, s1_m7, s1_m8;
  logic signed [MAT_W-1:0] s1_t1, s1_t2, s1_crsy, s1_srsy, s1_crcy, s1_srcy;
  logic signed [MAT_W-1:0] s1_sy, s1_cy;
  logic signed [MAT_W-1:0] s2_m0, s2_m3, s2_m6, s2_m7, s2_m8;
  logic signed [MAT_W-1:0] s2_crsy, s2_srsy, s2_crcy, s2_srcy;
  logic signed [MAT_W-1:0] s2_p1, s2_p2, s2_p3, s2_p4;

  assign xr_r = MAT_W'(sr);
  assign xc_r = MAT_W'(cr);
  assign xp_s = MAT_W'(sp);
  assign xp_c = MAT_W'(cp);
  assign xy_s = MAT_W'(sy);
  assign xy_c = MAT_W'(cy);

  // first products
  always_ff @(posedge clk) begin
    if (en) begin
      s1_m0   <= qmul(xp_c, xy_c);
      s1_m3   <= qmul(xp_c, xy_s);
      s1_m6   <= -xp_s;
      s1_m7   <= qmul(xr_r, xp_c);
      s1_m8   <= qmul(xc_r, xp_c);
      s1_t1   <= qmul(xr_r, xp_s);
      s1_t2   <= qmul(xc_r, xp_s);
      s1_crsy <= qmul(xc_r, xy_s);
      s1_srsy <= qmul(xr_r, xy_s);
      s1_crcy <= qmul(xc_r, xy_c);
      s1_srcy <= qmul(xr_r, xy_c);
      s1_sy   <= xy_s;
      s1_cy   <= xy_c;
    end
  end

  // chained products through sin(pitch)
  always_ff @(posedge clk) begin
    if (en) begin
      s2_m0   <= s1_m0;
      s2_m3   <= s1_m3;
      s2_m6   <= s1_m6;
      s2_m7   <= s1_m7;
      s2_m8   <= s1_m8;
      s2_crsy <= s1_crsy;
      s2_srsy <= s1_srsy;
      s2_crcy <= s1_crcy;
      s2_srcy <= s1_srcy;
      s2_p1   <= qmul(s1_t1, s1_cy);
      s2_p2   <= qmul(s1_t2, s1_cy);
      s2_p3   <= qmul(s1_t1, s1_sy);
      s2_p4   <= qmul(s1_t2, s1_sy);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= s2_m0;
      m[1] <= s2_p1 - s2_crsy;
      m[2] <= s2_srsy + s2_p2;
      m[3] <= s2_m3;
      m[4] <= s2_crcy + s2_p3;
      m[5] <= s2_p4 - s2_srcy;
      m[6] <= s2_m6;
      m[7] <= s2_m7;
      m[8] <= s2_m8;
    end
  end

endmodule

[sv/eac_compose.sv]
// five entries of the matrix product, exact sums rounded to q30
module eac_compose (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [eac_pkg::MAT_W-1:0] a [9],
  input  logic signed [eac_pkg::MAT_W-1:0] b [9],
  output eac_pkg::fsel_t                   f
);
  import eac_pkg::*;

  localparam int PW = 2 * MAT_W;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] CRND = SW'(64'sd536870912);

  logic signed [PW-1:0]  prod [5][3];
  logic signed [F_W-1:0] fe [5];

  // entry order: f20, f21, f22, f10, f00
  for (genvar e = 0; e < 5; e++) begin : g_entry
    localparam int ROW = (e == 3) ? 1 : ((e == 4) ? 0 : 2);
    localparam int COL = (e < 3) ? e : 0;
    logic signed [SW-1:0] sum;

    for (genvar k = 0; k < 3; k++) begin : g_term
      always_ff @(posedge clk) begin
        if (en) begin
          prod[e][k] <= a[ROW*3+k] * b[k*3+COL];
        end
      end
    end

    assign sum = SW'(prod[e][0]) + SW'(prod[e][1]) + SW'(prod[e][2]) + CRND;

    always_ff @(posedge clk) begin
      if (en) begin
        fe[e] <= sum[F_W+29:30];
      end
    end
  end

  assign f.f20 = fe[0];
  assign f.f21 = fe[1];
  assign f.f22 = fe[2];
  assign f.f10 = fe[3];
  assign f.f00 = fe[4];

endmodule

[sv/eac_asin_root.sv]
// asin front end: saturate, square, then restoring square root one bit per stage
module eac_asin_root (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [eac_pkg::F_W-1:0]    v,
  output logic signed [eac_pkg::SAT_W-1:0]  vsat,
  output logic        [eac_pkg::ROOT_W-1:0] root
);
  import eac_pkg::*;

  localparam logic signed [F_W-1:0] Q1_P = F_W'(Q_ONE);
  localparam logic signed [F_W-1:0] Q1_N = F_W'(-Q_ONE);
  localparam logic [RAD_W-1:0]      ONE_SQ = RAD_W'(1) << 60;

  logic signed [SAT_W-1:0]   s0_v;
  logic signed [SAT_W-1:0]   s1_v;
  logic signed [2*SAT_W-1:0] s1_sq;
  logic        [RAD_W-1:0]   rem [ROOT_W+1];
  logic        [ROOT_W-1:0]  qr  [ROOT_W+1];
  logic signed [SAT_W-1:0]   vs  [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (v > Q1_P) begin
        s0_v <= SAT_W'(Q1_P);
      end else if (v < Q1_N) begin
        s0_v <= SAT_W'(Q1_N);
      end else begin
        s0_v <= SAT_W'(v);
      end
      s1_v   <= s0_v;
      s1_sq  <= s0_v * s0_v;
      vs[0]  <= s1_v;
      rem[0] <= ONE_SQ - RAD_W'(s1_sq[60:0]);
      qr[0]  <= '0;
    end
  end

  for (genvar s = 0; s < ROOT_W; s++) begin : g_bit
    localparam int BI = ROOT_W - 1 - s;
    localparam logic [RAD_W-1:0] BSQ = RAD_W'(1) << (2 * BI);
    logic [RAD_W-1:0] trial;

    // (q + 2^i)^2 - q^2
    assign trial = (RAD_W'(qr[s]) << (BI + 1)) + BSQ;

    always_ff @(posedge clk) begin
      if (en) begin
        vs[s+1] <= vs[s];
        if (rem[s] >= trial) begin
          rem[s+1] <= rem[s] - trial;
          qr[s+1]  <= qr[s] | (ROOT_W'(1) << BI);
        end else begin
          rem[s+1] <= rem[s];
          qr[s+1]  <= qr[s];
        end
      end
    end
  end

  assign vsat = vs[ROOT_W];
  assign root = qr[ROOT_W];

endmodule

[sv/eac_atan2.sv]
// pipelined atan2 by vectoring-mode cordic
module eac_atan2 #(
  parameter int CORDIC_STEPS = eac_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [eac_pkg::F_W-1:0]  y_in,
  input  logic signed [eac_pkg::F_W-1:0]  x_in,
  output logic signed [eac_pkg::AZ_W-1:0] angle
);
  import eac_pkg::*;

  localparam logic signed [AZ_W-1:0] PI_Z = AZ_W'(Q_PI);

  logic signed [AT_W-1:0] xe, ye;
  logic signed [AT_W-1:0] vx [CORDIC_STEPS+1];
  logic signed [AT_W-1:0] vy [CORDIC_STEPS+1];
  logic signed [AZ_W-1:0] vz [CORDIC_STEPS+1];
  logic                   zf [CORDIC_STEPS+1];

  assign xe = AT_W'(x_in);
  assign ye = AT_W'(y_in);

  // left half plane: mirror through the origin and start from +-pi
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        vx[0] <= -xe;
        vy[0] <= -ye;
        vz[0] <= (y_in >= 0) ? PI_Z : -PI_Z;
      end else begin
        vx[0] <= xe;
        vy[0] <= ye;
        vz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    localparam logic signed [AZ_W-1:0] ATN = AZ_W'(atan_at(i));
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (vy[i] > 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + ATN;
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - ATN;
        end
      end
    end
  end

  assign angle = zf[CORDIC_STEPS] ? '0 : vz[CORDIC_STEPS];

endmodule

[sv/euler_angle_composition_top.sv]
// euler angle composition: two zyx attitudes multiplied and turned back into angles
// the pipeline depth comes mostly from the sin/cos cordic, the square root of the asin,
// which resolves one root bit per stage, and the atan2 cordic
// throughput: one transaction per cycle; the whole pipeline holds while out_stall keeps
// a waiting result, so in_stall follows it
// reset clears only the stage valid bits; the datapath registers carry no reset
module euler_angle_composition_top #(
  parameter int ANGLE_WIDTH  = eac_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = eac_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ANGLE_WIDTH-1:0]      start_roll,
  input  logic signed [ANGLE_WIDTH-1:0]      start_pitch,
  input  logic signed [ANGLE_WIDTH-1:0]      start_yaw,
  input  logic signed [ANGLE_WIDTH-1:0]      step_roll,
  input  logic signed [ANGLE_WIDTH-1:0]      step_pitch,
  input  logic signed [ANGLE_WIDTH-1:0]      step_yaw,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [eac_pkg::OUT_W-1:0]   final_roll,
  output logic signed [eac_pkg::PITCH_W-1:0] final_pitch,
  output logic signed [eac_pkg::OUT_W-1:0]   final_yaw
);
  import eac_pkg::*;

  // stage budget of each section
  localparam int RS        = (ANGLE_WIDTH > 16) ? ANGLE_WIDTH - 16 : 0;
  localparam int SC_STAGES = CORDIC_STEPS + RS + 4;
  localparam int ROT_STAGES  = 3;
  localparam int COMP_STAGES = 2;
  localparam int AT_STAGES   = CORDIC_STEPS + 1;
  localparam int LAT = SC_STAGES + ROT_STAGES + COMP_STAGES + ASIN_STAGES + AT_STAGES + 1;

  logic                    en;
  logic [LAT-1:0]          vpipe;

  logic signed [SIN_W-1:0] a_sr, a_cr, a_sp, a_cp, a_sy, a_cy;
  logic signed [SIN_W-1:0] b_sr, b_cr, b_sp, b_cp, b_sy, b_cy;
  logic signed [MAT_W-1:0] mat_a [9];
  logic signed [MAT_W-1:0] mat_b [9];
  fsel_t                   fsel;
  fsel_t                   fdly [ASIN_STAGES];

  logic signed [SAT_W-1:0]  vsat;
  logic        [ROOT_W-1:0] root;
  logic signed [AZ_W-1:0]   z_roll, z_pitch, z_yaw;
  logic signed [AZ_W:0]     z_pitch_neg;
  logic signed [OUT_W-1:0]  roll_q, pitch_q, yaw_q;

  // global pipeline enable: everything moves unless a finished result is held
  assign en       = !vpipe[LAT-1] || !out_stall;
  assign in_stall = !en;
  assign out_valid = vpipe[LAT-1];

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  // six sin/cos lanes, one per input angle
  eac_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_ar (
    .clk(clk), .en(en), .angle(start_roll), .sin_q(a_sr), .cos_q(a_cr)
  );
  eac_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_ap (
    .clk(clk), .en(en), .angle(start_pitch), .sin_q(a_sp), .cos_q(a_cp)
  );
  eac_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_ay (
    .clk(clk), .en(en), .angle(start_yaw), .sin_q(a_sy), .cos_q(a_cy)
  );
  eac_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_br (
    .clk(clk), .en(en), .angle(step_roll), .sin_q(b_sr), .cos_q(b_cr)
  );
  eac_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_bp (
    .clk(clk), .en(en), .angle(step_pitch), .sin_q(b_sp), .cos_q(b_cp)
  );
  eac_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_by (
    .clk(clk), .en(en), .angle(step_yaw), .sin_q(b_sy), .cos_q(b_cy)
  );

  // start attitude and increment as rotation matrices
  eac_rotation u_rot_a (
    .clk(clk), .en(en),
    .sr(a_sr), .cr(a_cr), .sp(a_sp), .cp(a_cp), .sy(a_sy), .cy(a_cy),
    .m(mat_a)
  );
  eac_rotation u_rot_b (
    .clk(clk), .en(en),
    .sr(b_sr), .cr(b_cr), .sp(b_sp), .cp(b_cp), .sy(b_sy), .cy(b_cy),
    .m(mat_b)
  );

  // only the five entries the angle extraction needs
  eac_compose u_comp (
    .clk(clk), .en(en), .a(mat_a), .b(mat_b), .f(fsel)
  );

  // pitch needs sqrt(1 - f20^2) first
  eac_asin_root u_asin (
    .clk(clk), .en(en), .v(fsel.f20), .vsat(vsat), .root(root)
  );

  // roll and yaw entries wait alongside the square root
  always_ff @(posedge clk) begin
    if (en) begin
      fdly[0] <= fsel;
    end
  end

  for (genvar k = 1; k < ASIN_STAGES; k++) begin : g_fdly
    always_ff @(posedge clk) begin
      if (en) begin
        fdly[k] <= fdly[k-1];
      end
    end
  end

  // three atan2 lanes in lockstep
  eac_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_at_roll (
    .clk(clk), .en(en),
    .y_in(fdly[ASIN_STAGES-1].f21), .x_in(fdly[ASIN_STAGES-1].f22),
    .angle(z_roll)
  );
  eac_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_at_pitch (
    .clk(clk), .en(en),
    .y_in(F_W'(vsat)), .x_in(signed'(F_W'(root))),
    .angle(z_pitch)
  );
  eac_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_at_yaw (
    .clk(clk), .en(en),
    .y_in(fdly[ASIN_STAGES-1].f10), .x_in(fdly[ASIN_STAGES-1].f00),
    .angle(z_yaw)
  );

  // pitch is minus asin
  assign z_pitch_neg = -((AZ_W+1)'(z_pitch));

  assign roll_q  = to_out((AZ_W+1)'(z_roll), OUT_PI);
  assign pitch_q = to_out(z_pitch_neg, OUT_HALF_PI);
  assign yaw_q   = to_out((AZ_W+1)'(z_yaw), OUT_PI);

  // output register, held while the consumer stalls
  always_ff @(posedge clk) begin
    if (en) begin
      final_roll  <= roll_q;
      final_pitch <= pitch_q[PITCH_W-1:0];
      final_yaw   <= yaw_q;
    end
  end

endmodule

[bench/eac_checker.sv]
// transaction monitor, angle composition predictor and result comparison
module eac_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] start_roll,
  input  logic signed [15:0] start_pitch,
  input  logic signed [15:0] start_yaw,
  input  logic signed [15:0] step_roll,
  input  logic signed [15:0] step_pitch,
  input  logic signed [15:0] step_yaw,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] final_roll,
  input  logic signed [14:0] final_pitch,
  input  logic signed [15:0] final_yaw,
  output int                 mismatches,
  output int                 taken,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint RND30       = 64'sd536870912;
  localparam int     STEPS       = 16;
  localparam longint ROLL_LIM    = 25736;
  localparam longint PITCH_LIM   = 12868;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } attitude_t;

  longint atan_q30 [STEPS] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                               33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                               524287, 262143, 131071, 65535, 32767};

  attitude_t attitude_q[$];

  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + RND30) >>> 30;
  endfunction

  function automatic void sine_cosine(input longint ang, output longint s, output longint c);
    longint r, x, y, dx, dy;
    bit flip;
    r = ang % TWO_PI_Q30;
    if (r < 0) r += TWO_PI_Q30;
    if (r > PI_Q30) r -= TWO_PI_Q30;
    flip = 1'b0;
    if (r > HALF_PI_Q30) begin
      r -= PI_Q30;
      flip = 1'b1;
    end else if (r < -HALF_PI_Q30) begin
      r += PI_Q30;
      flip = 1'b1;
    end
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (r >= 0) begin
        x -= dx; y += dy; r -= atan_q30[i];
      end else begin
        x += dx; y -= dy; r += atan_q30[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint arctan2(input longint y_in, input longint x_in);
    longint x, y, z, dx, dy;
    x = x_in;
    y = y_in;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q30 : -PI_Q30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_q30[i];
      end else begin
        x -= dx; y += dy; z -= atan_q30[i];
      end
    end
    return z;
  endfunction

  function automatic longint arcsin(input longint v_in);
    longint v;
    logic [63:0] n, res, b;
    v = v_in;
    if (v > ONE_Q30) v = ONE_Q30;
    if (v < -ONE_Q30) v = -ONE_Q30;
    n = 64'(ONE_Q30 * ONE_Q30) - 64'(v * v);
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return arctan2(v, longint'(res));
  endfunction

  function automatic void rotation(input logic signed [15:0] r, input logic signed [15:0] p,
                                   input logic signed [15:0] w, output longint m [9]);
    longint sr, cr, sp, cp, sy, cy;
    sine_cosine(longint'(r) * 131072, sr, cr);
    sine_cosine(longint'(p) * 131072, sp, cp);
    sine_cosine(longint'(w) * 131072, sy, cy);
    m[0] = mul_q30(cp, cy);
    m[1] = mul_q30(mul_q30(sr, sp), cy) - mul_q30(cr, sy);
    m[2] = mul_q30(sr, sy) + mul_q30(mul_q30(cr, sp), cy);
    m[3] = mul_q30(cp, sy);
    m[4] = mul_q30(cr, cy) + mul_q30(mul_q30(sr, sp), sy);
    m[5] = -mul_q30(sr, cy) + mul_q30(mul_q30(cr, sp), sy);
    m[6] = -sp;
    m[7] = mul_q30(sr, cp);
    m[8] = mul_q30(cr, cp);
  endfunction

  function automatic longint clamp_angle(input longint z, input longint lim);
    longint v;
    v = (z + 65536) >>> 17;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic attitude_t compose_attitude();
    longint a [9];
    longint b [9];
    longint f [9];
    attitude_t res;
    rotation(start_roll, start_pitch, start_yaw, a);
    rotation(step_roll, step_pitch, step_yaw, b);
    for (int row = 0; row < 3; row++)
      for (int col = 0; col < 3; col++)
        f[row*3+col] = (a[row*3] * b[col] + a[row*3+1] * b[3+col]
                        + a[row*3+2] * b[6+col] + RND30) >>> 30;
    res.roll  = 16'(clamp_angle(arctan2(f[7], f[8]), ROLL_LIM));
    res.pitch = 15'(clamp_angle(-arcsin(f[6]), PITCH_LIM));
    res.yaw   = 16'(clamp_angle(arctan2(f[3], f[0]), ROLL_LIM));
    return res;
  endfunction

  assign pending = attitude_q.size();

  always @(posedge clk) begin
    attitude_t want;
    if (rst) begin
      mismatches <= 0;
      taken      <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        attitude_q.push_back(compose_attitude());
        taken <= taken + 1;
      end
      if (out_valid && !out_stall) begin
        if (attitude_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result roll %0d pitch %0d yaw %0d",
                     final_roll, final_pitch, final_yaw);
          mismatches <= mismatches + 1;
        end else begin
          want = attitude_q.pop_front();
          if (want.roll !== final_roll || want.pitch !== final_pitch
              || want.yaw !== final_yaw) begin
            if (mismatches < 10)
              $display("mismatch: want roll %0d pitch %0d yaw %0d, got %0d %0d %0d",
                       want.roll, want.pitch, want.yaw, final_roll, final_pitch, final_yaw);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

[bench/tb_euler_angle_composition_top.sv]
// testbench top: stimulus, flow control and verdict for the euler angle composition block
module tb_euler_angle_composition_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] start_roll = '0, start_pitch = '0, start_yaw = '0;
  logic signed [15:0] step_roll = '0, step_pitch = '0, step_yaw = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] final_roll, final_yaw;
  logic signed [14:0] final_pitch;
  int                 mismatches, taken, pending;

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  euler_angle_composition_top dut (
    .clk, .rst, .in_valid, .in_stall,
    .start_roll, .start_pitch, .start_yaw, .step_roll, .step_pitch, .step_yaw,
    .out_valid, .out_stall, .final_roll, .final_pitch, .final_yaw
  );

  eac_checker u_checker (
    .clk, .rst, .in_valid, .in_stall,
    .start_roll, .start_pitch, .start_yaw, .step_roll, .step_pitch, .step_yaw,
    .out_valid, .out_stall, .final_roll, .final_pitch, .final_yaw,
    .mismatches, .taken, .pending
  );

  // receiver: phases of no stall, light stall and heavy stall
  int stall_phase = 0;
  int stall_left  = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_phase = $urandom_range(0, 2);
        stall_left  = $urandom_range(10, 150);
      end
      stall_left--;
      case (stall_phase)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  int burst_left = 0;

  // present one transaction at a falling edge and hold it until taken
  task automatic send_attitude(input logic signed [15:0] sr, sp, sy, tr, tp, ty);
    int target;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start_roll <= sr; start_pitch <= sp; start_yaw <= sy;
    step_roll  <= tr; step_pitch  <= tp; step_yaw  <= ty;
    in_valid   <= 1'b1;
    target = taken + 1;
    do @(negedge clk); while (taken < target);
  endtask

  // random angle: full range, small, or close to plus or minus pi/2
  function automatic logic signed [15:0] pick_angle(input int kind);
    case (kind)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'(int'($urandom_range(0, 4000)) - 2000);
      default: return 16'(($urandom_range(0, 1) ? 12868 : -12868)
                          + int'($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  initial begin
    logic signed [15:0] v [6];
    int kind;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: zero, field extremes, wrap past pi, gimbal lock and asin saturation
    send_attitude(0, 0, 0, 0, 0, 0);
    send_attitude(-32768, -32768, -32768, -32768, -32768, -32768);
    send_attitude(32767, 32767, 32767, 32767, 32767, 32767);
    send_attitude(-32768, 32767, -32768, 32767, -32768, 32767);
    send_attitude(25736, 0, -25736, 0, 0, 0);
    send_attitude(30000, -30000, 26000, -26000, 25735, 25737);
    send_attitude(0, 12868, 0, 0, 0, 0);
    send_attitude(0, -12868, 0, 0, 0, 0);
    send_attitude(0, 6434, 0, 0, 6434, 0);
    send_attitude(0, -6434, 0, 0, -6434, 0);
    send_attitude(0, 12868, 0, 0, 100, 0);
    send_attitude(0, 12868, 5000, 3000, 0, 0);
    send_attitude(12868, 12868, 12868, 0, 0, 0);
    send_attitude(0, 0, 25736, 0, 0, 25736);
    send_attitude(0, 0, 0, 25736, 12868, 0);
    send_attitude(1, 1, 1, -1, -1, -1);
    send_attitude(16384, -16384, 8192, -8192, 4096, -4096);
    send_attitude(0, 25736, 0, 0, 0, 0);

    // random: mostly full range, some near gimbal lock and small angles
    repeat (700) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 6; i++) begin
        if (kind < 6) v[i] = pick_angle(0);
        else if (kind < 8) v[i] = pick_angle(1);
        else v[i] = pick_angle((i == 1 || i == 4) ? 2 : $urandom_range(0, 1));
      end
      send_attitude(v[0], v[1], v[2], v[3], v[4], v[5]);
    end
    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("** euler_angle_composition_top: PASSED **");
    end else begin
      $display("** euler_angle_composition_top: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4ms;
    $display("** euler_angle_composition_top: FAILED **");
    $finish;
  end

endmodule

[euler_angle_composition_top.f]
sv/eac_pkg.sv
sv/eac_sincos.sv
sv/eac_rotation.sv
sv/eac_compose.sv
sv/eac_asin_root.sv
sv/eac_atan2.sv
sv/euler_angle_composition_top.sv
bench/eac_checker.sv
bench/tb_euler_angle_composition_top.sv
